### rtl/mssw_pkg.sv
package mssw_pkg;

  // table size and derived widths
  localparam int SLOT_COUNT = 8;
  localparam int SLOT_IW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int TIME_W     = 32;
  localparam int CMD_W      = 2;
  localparam int IDX_W      = 3;
  localparam int NEW_W      = 3;

  // command codes
  localparam logic [CMD_W-1:0] CMD_NEW    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FEED   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd3;

  // table write operations
  localparam logic [1:0] WR_NONE = 2'd0;
  localparam logic [1:0] WR_ARM  = 2'd1;  // store start time (and timeout if set_tmo), mark active
  localparam logic [1:0] WR_FREE = 2'd2;  // clear active

  typedef struct packed {
    logic [1:0]         op;
    logic               set_tmo;
    logic [SLOT_IW-1:0] addr;
    logic [TIME_W-1:0]  tmo;
    logic [TIME_W-1:0]  start;
  } tbl_wr_t;

endpackage

### rtl/mssw_table.sv
module mssw_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mssw_pkg::tbl_wr_t             wr,
  input  logic [mssw_pkg::SLOT_IW-1:0]  rd_addr,
  output logic                          rd_active,
  output logic [mssw_pkg::TIME_W-1:0]   rd_timeout,
  output logic [mssw_pkg::TIME_W-1:0]   rd_start
);
  import mssw_pkg::*;

  logic [TIME_W-1:0]     timeout_r [SLOT_COUNT];
  logic [TIME_W-1:0]     start_r   [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] active_r;

  // payload store: no reset, contents undefined until claimed
  always_ff @(posedge clk) begin
    if (wr.op == WR_ARM) begin
      start_r[wr.addr] <= wr.start;
      if (wr.set_tmo) begin
        timeout_r[wr.addr] <= wr.tmo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (wr.op == WR_ARM) begin
      active_r[wr.addr] <= 1'b1;
    end else if (wr.op == WR_FREE) begin
      active_r[wr.addr] <= 1'b0;
    end
  end

  assign rd_active  = active_r[rd_addr];
  assign rd_timeout = timeout_r[rd_addr];
  assign rd_start   = start_r[rd_addr];

endmodule

### rtl/mssw_chk.sv
module mssw_chk (
  input  logic                         active,
  input  logic [mssw_pkg::TIME_W-1:0]  now,
  input  logic [mssw_pkg::TIME_W-1:0]  start,
  input  logic [mssw_pkg::TIME_W-1:0]  timeout,
  output logic                         expired
);
  import mssw_pkg::*;

  logic [TIME_W-1:0] elapsed;

  // wraps modulo 2^32
  assign elapsed = TIME_W'(now - start);
  assign expired = active && (elapsed > timeout);

endmodule

### rtl/mssw_seq.sv
module mssw_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mssw_pkg::CMD_W-1:0]    in_command,
  input  logic [mssw_pkg::IDX_W-1:0]    in_slot_index,
  input  logic [mssw_pkg::TIME_W-1:0]   in_timeout_ms,
  input  logic [mssw_pkg::TIME_W-1:0]   in_now_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_ok,
  output logic [mssw_pkg::NEW_W-1:0]    out_new_slot,
  output logic [mssw_pkg::SLOT_IW-1:0]  rd_addr,
  input  logic                          rd_active,
  input  logic                          expired,
  output logic [mssw_pkg::TIME_W-1:0]   now_q,
  output mssw_pkg::tbl_wr_t             wr
);
  import mssw_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam logic [SLOT_IW-1:0] LAST_SLOT = SLOT_IW'(SLOT_COUNT - 1);

  logic [1:0]         state_r, state_nxt;
  logic [SLOT_IW-1:0] cnt_r, cnt_nxt;
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [TIME_W-1:0]  tmo_r, tmo_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic               fail_r, fail_nxt;
  logic               res_ok_r, res_ok_nxt;
  logic [NEW_W-1:0]   res_slot_r, res_slot_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic [NEW_W-1:0]   out_slot_r, out_slot_nxt;
  logic               idx_ok;

  assign idx_ok = (32'(in_slot_index) < 32'(SLOT_COUNT));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd_nxt       = cmd_r;
    tmo_nxt       = tmo_r;
    now_nxt       = now_r;
    fail_nxt      = fail_r;
    res_ok_nxt    = res_ok_r;
    res_slot_nxt  = res_slot_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_slot_nxt  = out_slot_r;
    wr            = '0;
    wr.op         = WR_NONE;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt      = in_command;
          tmo_nxt      = in_timeout_ms;
          now_nxt      = in_now_ms;
          cnt_nxt      = '0;
          fail_nxt     = 1'b0;
          res_ok_nxt   = 1'b1;
          res_slot_nxt = '0;
          unique case (in_command) inside
            CMD_NEW, CMD_CHECK: begin
              state_nxt = S_SCAN;
            end
            CMD_DELETE: begin
              if (idx_ok) begin
                wr.op   = WR_FREE;
                wr.addr = SLOT_IW'(in_slot_index);
              end
              state_nxt = S_DONE;
            end
            default: begin
              // feed: restart timer, keep stored timeout
              if (idx_ok) begin
                wr.op    = WR_ARM;
                wr.addr  = SLOT_IW'(in_slot_index);
                wr.start = in_now_ms;
              end
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (cmd_r == CMD_NEW) begin
          if (!rd_active) begin
            wr.op        = WR_ARM;
            wr.set_tmo   = 1'b1;
            wr.addr      = cnt_r;
            wr.tmo       = tmo_r;
            wr.start     = now_r;
            res_ok_nxt   = 1'b1;
            res_slot_nxt = NEW_W'(cnt_r);
            state_nxt    = S_DONE;
          end else if (cnt_r == LAST_SLOT) begin
            res_ok_nxt = 1'b0;
            state_nxt  = S_DONE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end else begin
          fail_nxt = fail_r | expired;
          if (cnt_r == LAST_SLOT) begin
            res_ok_nxt = !(fail_r | expired);
            state_nxt  = S_DONE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_slot_nxt  = res_slot_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    cmd_r      <= cmd_nxt;
    tmo_r      <= tmo_nxt;
    now_r      <= now_nxt;
    fail_r     <= fail_nxt;
    res_ok_r   <= res_ok_nxt;
    res_slot_r <= res_slot_nxt;
    out_ok_r   <= out_ok_nxt;
    out_slot_r <= out_slot_nxt;
  end

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_ok       = out_ok_r;
  assign out_new_slot = out_slot_r;
  assign rd_addr      = cnt_r;
  assign now_q        = now_r;

endmodule

### rtl/multi_slot_software_watchdog.sv
// Multi-slot software watchdog.
// Input channel (in_valid / in_stall): one transaction per command with
//   in_command (new, delete, feed, check), in_slot_index, in_timeout_ms and
//   the current millisecond tick in_now_ms.
// Result channel (out_valid / out_stall): one transaction per command with
//   out_ok and out_new_slot (claimed slot for new, else 0).
// Delete / feed write the table at the accepting edge and then load
//   the result; new scans from slot 0 to the first free slot (the
//   whole table when full); check scans every slot. in_stall drops at
//   the edge that raises out_valid. The scan steps one slot per cycle
//   through the table, sharing one subtract-and-compare unit for check.
// in_stall is high from acceptance until the result is loaded into the
//   output register; a finished result can wait there while the next
//   command is accepted.
// If the receiver stalls, the result stays in the output register and the
//   next result is held in the sequencer until the register frees up.
// Reset (rst_n low, synchronous) clears all active marks and drops out_valid;
//   stored timeouts and start times are left as they are.
module multi_slot_software_watchdog (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mssw_pkg::CMD_W-1:0]   in_command,
  input  logic [mssw_pkg::IDX_W-1:0]   in_slot_index,
  input  logic [mssw_pkg::TIME_W-1:0]  in_timeout_ms,
  input  logic [mssw_pkg::TIME_W-1:0]  in_now_ms,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_ok,
  output logic [mssw_pkg::NEW_W-1:0]   out_new_slot
);
  import mssw_pkg::*;

  // scan address and table read data
  logic [SLOT_IW-1:0] rd_addr;
  logic               rd_active;
  logic [TIME_W-1:0]  rd_timeout;
  logic [TIME_W-1:0]  rd_start;
  // latched command time for the shared compare
  logic [TIME_W-1:0]  now_q;
  logic               expired;
  tbl_wr_t            wr;

  // sequencer: handshakes, scan counter, result and output registers
  mssw_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_slot_index(in_slot_index),
    .in_timeout_ms(in_timeout_ms),
    .in_now_ms    (in_now_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ok       (out_ok),
    .out_new_slot (out_new_slot),
    .rd_addr      (rd_addr),
    .rd_active    (rd_active),
    .expired      (expired),
    .now_q        (now_q),
    .wr           (wr)
  );

  // slot table: timeouts, start times, active marks
  mssw_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .rd_active (rd_active),
    .rd_timeout(rd_timeout),
    .rd_start  (rd_start)
  );

  // shared elapsed-time compare, one slot per cycle
  mssw_chk u_chk (
    .active (rd_active),
    .now    (now_q),
    .start  (rd_start),
    .timeout(rd_timeout),
    .expired(expired)
  );

endmodule

### rtl/mssw_chkr.sv
module mssw_chkr (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_ok,
  input logic [mssw_pkg::NEW_W-1:0]   out_new_slot
);

  // held result is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a nonzero slot is only reported for a successful claim
  a_slot_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_new_slot != '0) |-> out_ok)
    else $error("slot reported without success");

  // one command at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second command taken while busy");

  // reset empties the output register
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind multi_slot_software_watchdog mssw_chkr u_mssw_chkr (.*);
